// File: design/wbss_pkg.sv
package wbss_pkg;

   // signature depth and derived widths
   localparam int MaxPattern = 128;
   localparam int ShiftW     = $clog2(MaxPattern);
   localparam int LenW       = $clog2(MaxPattern + 1);

   // fixed field widths
   localparam int IdxW   = 7;
   localparam int ByteW  = 8;
   localparam int CfgW   = 8;
   localparam int PosW   = 32;
   localparam int TotalW = 16;
   localparam int WideW  = IdxW + ShiftW;

   // stream payload widths, padded to whole bytes
   localparam int ReqDataW = 32;
   localparam int ReqPadW  = ReqDataW - (IdxW + ByteW + 1 + ByteW + 1);
   localparam int RspDataW = 56;
   localparam int RspPadW  = RspDataW - (1 + PosW + TotalW);

   // item kinds carried on the user sideband
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_SCAN = 1'b1
   } cmd_type;

   // one signature entry
   typedef struct packed {
      logic             wild;
      logic [ByteW-1:0] value;
   } entry_type;

   localparam entry_type WildEntry = '{wild: 1'b1, value: '0};

   // request payload, lowest field last
   typedef struct packed {
      logic [ReqPadW-1:0] pad;
      logic               region_start;
      logic [ByteW-1:0]   data_byte;
      logic               entry_wildcard;
      logic [ByteW-1:0]   entry_byte;
      logic [IdxW-1:0]    entry_index;
   } req_data_type;

   // response payload, lowest field last
   typedef struct packed {
      logic [RspPadW-1:0] pad;
      logic [TotalW-1:0]  match_total;
      logic [PosW-1:0]    match_offset;
      logic               match;
   } rsp_data_type;

   // signature write from an accepted load item
   typedef struct packed {
      logic             write;
      logic [IdxW-1:0]  index;
      entry_type        entry;
   } load_type;

   // window update from an accepted scan item
   typedef struct packed {
      logic             shift;
      logic [ByteW-1:0] data_byte;
      logic             region_start;
   } scan_type;

endpackage

// File: design/wbss_pattern.sv
module wbss_pattern (
   input  logic                clock,
   input  wbss_pkg::load_type  load,
   input  logic [wbss_pkg::LenW-1:0] act_len,
   output wbss_pkg::entry_type aligned [wbss_pkg::MaxPattern]
);
   import wbss_pkg::*;

   entry_type        store_ff [MaxPattern];
   logic [ShiftW-1:0] shift;

   // signature entries, one write port, no reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxPattern; k++) begin
         if (load.write && ({{ShiftW{1'b0}}, load.index} == WideW'(k))) begin
            store_ff[k] <= load.entry;
         end
      end
   end

   // entries move up so the last one lines up with the newest byte
   assign shift = ShiftW'(MaxPattern - int'(act_len));

   // log shifter, vacated low slots become don't care
   always_comb begin
      entry_type cur  [MaxPattern];
      entry_type prev [MaxPattern];
      cur = store_ff;
      for (int s = 0; s < ShiftW; s++) begin
         prev = cur;
         if (shift[s]) begin
            for (int k = 0; k < MaxPattern; k++) begin
               if (k >= (1 << s)) begin
                  cur[k] = prev[k - (1 << s)];
               end else begin
                  cur[k] = WildEntry;
               end
            end
         end
      end
      aligned = cur;
   end

endmodule

// File: design/wbss_window.sv
module wbss_window (
   input  logic                      clock,
   input  logic                      reset,
   input  wbss_pkg::scan_type        scan,
   output logic [wbss_pkg::ByteW-1:0] window [wbss_pkg::MaxPattern],
   output logic [wbss_pkg::PosW-1:0]  position
);
   import wbss_pkg::*;

   logic [ByteW-1:0] window_ff [MaxPattern];
   logic [ByteW-1:0] window_in [MaxPattern];
   logic [PosW-1:0]  position_ff;
   logic [PosW-1:0]  position_in;

   // shift in the scanned byte, newest at the top slot
   always_comb begin
      window_in   = window_ff;
      position_in = position_ff;
      if (scan.shift) begin
         for (int k = 0; k < MaxPattern - 1; k++) begin
            window_in[k] = window_ff[k + 1];
         end
         window_in[MaxPattern - 1] = scan.data_byte;
         if (scan.region_start) begin
            position_in = PosW'(1);
         end else if (position_ff != '1) begin
            position_in = position_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MaxPattern; k++) begin
            window_ff[k] <= '0;
         end
         position_ff <= '0;
      end else begin
         window_ff   <= window_in;
         position_ff <= position_in;
      end
   end

   assign window   = window_ff;
   assign position = position_ff;

endmodule

// File: design/wbss_match.sv
module wbss_match (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        eval,
   input  logic [wbss_pkg::ByteW-1:0]  window [wbss_pkg::MaxPattern],
   input  wbss_pkg::entry_type         aligned [wbss_pkg::MaxPattern],
   input  logic [wbss_pkg::LenW-1:0]   act_len,
   input  logic [wbss_pkg::PosW-1:0]   position,
   output logic                        match,
   output logic [wbss_pkg::PosW-1:0]   match_offset,
   output logic [wbss_pkg::TotalW-1:0] match_total
);
   import wbss_pkg::*;

   logic [MaxPattern-1:0] slot_ok;
   logic                  hit;
   logic [PosW-1:0]       offset;
   logic [TotalW-1:0]     count_ff;
   logic [TotalW-1:0]     count_in;
   logic                  match_ff;
   logic [PosW-1:0]       offset_ff;

   // per-slot compare against the aligned signature
   always_comb begin
      for (int k = 0; k < MaxPattern; k++) begin
         slot_ok[k] = aligned[k].wild || (aligned[k].value == window[k]);
      end
   end

   // region must hold a full window of bytes
   assign hit    = (act_len != '0) && (position >= PosW'(act_len)) && (&slot_ok);
   assign offset = position - PosW'(act_len);

   // saturating match count
   assign count_in = (eval && hit && (count_ff != '1)) ? count_ff + TotalW'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (eval) begin
         match_ff  <= hit;
         offset_ff <= hit ? offset : '0;
      end
   end

   assign match        = match_ff;
   assign match_offset = offset_ff;
   assign match_total  = count_ff;

   // count never falls
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("match count decreased");

   // count moves by one and only with a reported match
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + TotalW'(1)) && match_ff)
      else $error("match count moved without a match");

   // a reported match had a full window in its region
   assert property (@(posedge clock) disable iff (reset)
      eval |=> !match_ff || ($past(position) >= PosW'($past(act_len))))
      else $error("match reported on a short region");

endmodule

// File: design/wildcard_byte_signature_scanner.sv
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tuser: cmd; tdata: load or scan fields
// rsp      out        rsp_tvalid/rsp_tready  tdata: match, match_offset, match_total
// csr      in         csr_we                 csr_wdata: pattern_length
//
// one item per cycle sustained while no result stalls; a scan result passes eval_ff, then
// rsp_valid_ff; the full signature is compared against the window once per scan item
// load items produce no result; scan items produce exactly one
// reset clears the window, region offset, match count and length (to 1);
// the signature store is not cleared and needs no clearing pass
// a stalled result holds the evaluate stage, and req_tready drops only then
module wildcard_byte_signature_scanner (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [6:0] entry_index, [14:7] entry_byte, [15] entry_wildcard,
   // [23:16] data_byte, [24] region_start, [31:25] zero
   input  logic [wbss_pkg::ReqDataW-1:0]    req_tdata,
   // [0] cmd
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] match, [32:1] match_offset, [48:33] match_total, [55:49] zero
   output logic [wbss_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                             csr_we,
   input  logic [wbss_pkg::CfgW-1:0]        csr_wdata
);
   import wbss_pkg::*;

   req_data_type     req_data;
   rsp_data_type     rsp_data;
   logic             req_fire;
   logic             is_scan;
   logic             out_free;
   logic             eval_fire;
   logic             eval_ff;
   logic             eval_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CfgW-1:0]  length_ff;
   logic [LenW-1:0]  act_len;
   load_type         load;
   scan_type         scan;
   entry_type        aligned [MaxPattern];
   logic [ByteW-1:0] window [MaxPattern];
   logic [PosW-1:0]  position;
   logic             match;
   logic [PosW-1:0]  match_offset;
   logic [TotalW-1:0] match_total;

   assign req_data = req_tdata;
   assign is_scan  = (cmd_type'(req_tuser) == CMD_SCAN);

   // handshake: evaluate stage drains whenever the result slot frees up
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign eval_fire  = eval_ff && out_free;
   assign req_tready = !eval_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign eval_in      = req_fire ? is_scan : (eval_ff && !out_free);
   assign rsp_valid_in = eval_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         length_ff    <= CfgW'(1);
      end else begin
         eval_ff      <= eval_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            length_ff <= csr_wdata;
         end
      end
   end

   // length in use, capped at the store depth
   assign act_len = (int'(length_ff) > MaxPattern) ? LenW'(MaxPattern) : LenW'(length_ff);

   // state updates for the accepted item
   assign load.write       = req_fire && !is_scan;
   assign load.index       = req_data.entry_index;
   assign load.entry.wild  = req_data.entry_wildcard;
   assign load.entry.value = req_data.entry_byte;

   assign scan.shift        = req_fire && is_scan;
   assign scan.data_byte    = req_data.data_byte;
   assign scan.region_start = req_data.region_start;

   wbss_pattern u_pattern (
      .clock   (clock),
      .load    (load),
      .act_len (act_len),
      .aligned (aligned)
   );

   wbss_window u_window (
      .clock    (clock),
      .reset    (reset),
      .scan     (scan),
      .window   (window),
      .position (position)
   );

   wbss_match u_match (
      .clock        (clock),
      .reset        (reset),
      .eval         (eval_fire),
      .window       (window),
      .aligned      (aligned),
      .act_len      (act_len),
      .position     (position),
      .match        (match),
      .match_offset (match_offset),
      .match_total  (match_total)
   );

   // result packing
   assign rsp_data.pad          = '0;
   assign rsp_data.match_total  = match_total;
   assign rsp_data.match_offset = match_offset;
   assign rsp_data.match        = match;
   assign rsp_tdata             = rsp_data;
   assign rsp_tvalid            = rsp_valid_ff;

   // a scan item waiting on a full result slot stays put
   assert property (@(posedge clock) disable iff (reset)
      (eval_ff && !out_free) |=> eval_ff)
      else $error("pending scan item dropped");

   // a new result only ever comes from the evaluate stage
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(eval_ff))
      else $error("result appeared without a scan item");

   // no input taken while a scan item is blocked
   assert property (@(posedge clock) disable iff (reset)
      (eval_ff && rsp_valid_ff && !rsp_tready) |-> !req_fire)
      else $error("item accepted while evaluate stage blocked");

endmodule
